### hdl/pbc_pkg.sv
// Package: constants, types and hash function shared by the predictor byte codec.
`default_nettype none
package pbc_pkg;

  localparam int unsigned TableDepth = 32768;
  localparam int unsigned TableAw    = $clog2(TableDepth);
  localparam int unsigned GroupSize  = 8;
  localparam int unsigned HashShift  = 7;
  localparam logic [7:0]  FillByte   = 8'h20;

  localparam logic DirCompress   = 1'b0;
  localparam logic DirDecompress = 1'b1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_C_CMP = 7'b0000100,
    S_C_EMT = 7'b0001000,
    S_D_IN  = 7'b0010000,
    S_D_RD  = 7'b0100000,
    S_D_OUT = 7'b1000000
  } pbc_state_e;

  typedef struct packed {
    logic cfg_wr;    // direction register write
    logic restart;   // return stream state to reset values
    logic clr_we;    // clearing pass write
    logic rd_en;     // table read at current hash
    logic latch;     // capture input transaction
    logic c_cmp;     // compress: compare guess, update
    logic c_emit;    // compress: load next flag/literal into output
    logic d_in;      // decompress: consume input byte
    logic d_out;     // decompress: emit predicted byte
    logic d_finish;  // decompress: close out group handling
  } pbc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic dir;
    logic eos;
    logic awaiting;
    logic group_done;
    logic emit_last;
    logic loop_go;
    logic out_free;
  } pbc_stat_t;

  function automatic logic [TableAw-1:0] pbc_hash(input logic [7:0] prev,
                                                  input logic [7:0] prev_prev);
    logic [TableAw-1:0] a;
    logic [TableAw-1:0] b;
    a = TableAw'(prev);
    b = TableAw'({prev_prev, HashShift'(0)});
    return a ^ b;
  endfunction

endpackage
`default_nettype wire

### hdl/pbc_dp.sv
// Datapath: guess table memory, history, group state and output register.
`default_nettype none
module pbc_dp
  import pbc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pbc_cmd_t   cmd_i,
  output pbc_stat_t       stat_o,
  input  wire logic       cfg_data_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_eos_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            out_done_o
);

  logic [7:0] mem [TableDepth];
  logic [7:0] rdata_q;

  logic               dir_q;
  logic [TableAw-1:0] clr_cnt_q;
  logic [7:0]         byte_q;
  logic               eos_q;
  logic [7:0]         prev_q, pprev_q;
  logic [7:0]         flag_q;
  logic [3:0]         pos_q;
  logic [3:0]         cnt_q;
  logic [3:0]         emit_idx_q;
  logic               await_q;
  logic [7:0]         lit_q [GroupSize];

  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_last_q, out_done_q;

  logic [TableAw-1:0] hash;
  logic               hit;
  logic               mem_we;
  logic [TableAw-1:0] mem_waddr;
  logic [7:0]         mem_wdata;
  logic [3:0]         pos_nxt;
  logic               d_last;
  logic               d_lit;
  logic               load;
  logic [7:0]         load_byte;
  logic               load_last;
  logic [7:0]         emit_byte;
  logic [2:0]         lit_rd_idx;
  logic               emit_last;

  assign hash       = pbc_hash(prev_q, pprev_q);
  assign hit        = (rdata_q == byte_q);
  assign pos_nxt    = pos_q + 4'd1;
  // next result is the last one if the group ends or the next bit wants a literal
  assign d_last     = pos_nxt[3] | ~flag_q[pos_nxt[2:0]];
  assign d_lit      = cmd_i.d_in & ~await_q;
  assign emit_last  = (emit_idx_q == cnt_q);
  assign lit_rd_idx = 3'(emit_idx_q - 4'd1);
  assign emit_byte  = (emit_idx_q == 4'd0) ? flag_q : lit_q[lit_rd_idx];

  assign mem_we    = cmd_i.clr_we | (cmd_i.c_cmp & ~hit) | d_lit;
  assign mem_waddr = cmd_i.clr_we ? clr_cnt_q : hash;
  assign mem_wdata = cmd_i.clr_we ? FillByte : byte_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[hash];
    end
  end

  always_comb begin
    load      = 1'b0;
    load_byte = emit_byte;
    load_last = emit_last;
    if (cmd_i.c_emit) begin
      load = 1'b1;
    end else if (d_lit) begin
      load      = 1'b1;
      load_byte = byte_q;
      load_last = d_last;
    end else if (cmd_i.d_out) begin
      load      = 1'b1;
      load_byte = rdata_q;
      load_last = d_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= DirCompress;
      clr_cnt_q   <= '0;
      eos_q       <= 1'b0;
      prev_q      <= '0;
      pprev_q     <= '0;
      flag_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      emit_idx_q  <= '0;
      await_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr) begin
        dir_q <= cfg_data_i;
      end
      if (cmd_i.latch) begin
        eos_q <= in_eos_i;
      end

      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.restart) begin
        clr_cnt_q  <= '0;
        prev_q     <= '0;
        pprev_q    <= '0;
        flag_q     <= '0;
        pos_q      <= '0;
        cnt_q      <= '0;
        emit_idx_q <= '0;
        await_q    <= 1'b1;
      end else begin
        if (cmd_i.clr_we) begin
          clr_cnt_q <= clr_cnt_q + TableAw'(1);
        end
        if (cmd_i.c_cmp) begin
          if (hit) begin
            flag_q[pos_q[2:0]] <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
          pprev_q <= prev_q;
          prev_q  <= byte_q;
          pos_q   <= pos_nxt;
        end
        if (cmd_i.c_emit) begin
          if (emit_last) begin
            emit_idx_q <= '0;
            flag_q     <= '0;
            pos_q      <= '0;
            cnt_q      <= '0;
          end else begin
            emit_idx_q <= emit_idx_q + 4'd1;
          end
        end
        if (cmd_i.d_in) begin
          if (await_q) begin
            flag_q  <= byte_q;
            pos_q   <= '0;
            await_q <= 1'b0;
          end else begin
            pprev_q <= prev_q;
            prev_q  <= byte_q;
            pos_q   <= pos_nxt;
          end
        end
        if (cmd_i.d_out) begin
          pprev_q <= prev_q;
          prev_q  <= rdata_q;
          pos_q   <= pos_nxt;
        end
        if (cmd_i.d_finish && pos_q[3]) begin
          pos_q   <= '0;
          await_q <= 1'b1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.c_cmp && !hit) begin
      lit_q[cnt_q[2:0]] <= byte_q;
    end
    if (load) begin
      out_byte_q <= load_byte;
      out_last_q <= load_last;
      out_done_q <= load_last & eos_q;
    end
  end

  assign stat_o.clr_done   = (clr_cnt_q == '1);
  assign stat_o.dir        = dir_q;
  assign stat_o.eos        = eos_q;
  assign stat_o.awaiting   = await_q;
  assign stat_o.group_done = (pos_q == 4'(GroupSize - 1)) | eos_q;
  assign stat_o.emit_last  = emit_last;
  assign stat_o.loop_go    = ~pos_q[3] & flag_q[pos_q[2:0]];
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(GroupSize))
    else $error("literal count exceeds group size");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 4'(GroupSize))
    else $error("group position out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> stat_o.out_free)
    else $error("output register overwritten before taken");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.c_cmp && !hit && !cmd_i.restart) |=> cnt_q == $past(cnt_q) + 4'd1)
    else $error("mismatch not counted as literal");
`endif

endmodule
`default_nettype wire

### hdl/pbc_ctrl.sv
// Controller: state machine sequencing table clear, compress and decompress steps.
`default_nettype none
module pbc_ctrl
  import pbc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      cfg_valid_i,
  input  wire pbc_stat_t stat_i,
  output pbc_cmd_t       cmd_o
);

  pbc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.rd_en = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = (stat_i.dir == DirDecompress) ? S_D_IN : S_C_CMP;
        end
      end
      S_C_CMP: begin
        cmd_o.c_cmp = 1'b1;
        state_d     = stat_i.group_done ? S_C_EMT : S_IDLE;
      end
      S_C_EMT: begin
        if (stat_i.out_free) begin
          cmd_o.c_emit = 1'b1;
          if (stat_i.emit_last) begin
            cmd_o.restart = stat_i.eos;
            state_d       = stat_i.eos ? S_CLEAR : S_IDLE;
          end
        end
      end
      S_D_IN: begin
        if (stat_i.awaiting || stat_i.out_free) begin
          cmd_o.d_in = 1'b1;
          state_d    = S_D_RD;
        end
      end
      S_D_RD: begin
        // history was updated last cycle, so the read sees any fresh write
        if (stat_i.loop_go) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_D_OUT;
        end else begin
          cmd_o.d_finish = 1'b1;
          cmd_o.restart  = stat_i.eos;
          state_d        = stat_i.eos ? S_CLEAR : S_IDLE;
        end
      end
      S_D_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.d_out = 1'b1;
          state_d     = S_D_RD;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    if (cfg_valid_i) begin
      cmd_o         = '0;
      cmd_o.cfg_wr  = 1'b1;
      cmd_o.restart = 1'b1;
      in_ready_o    = 1'b0;
      state_d       = S_CLEAR;
    end
  end

`ifndef SYNTH
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> state_q == S_CLEAR)
    else $error("config write did not start clearing pass");

  a_clear_no_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_eos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.restart && !cfg_valid_i) |-> stat_i.eos)
    else $error("restart without end of stream");
`endif

endmodule
`default_nettype wire

### hdl/predictor_byte_codec.sv
// Top level: predictor byte codec, controller plus datapath.
//
//  channel   | direction | handshake               | payload
//  s_axis    | in        | s_axis_tvalid/tready    | tdata data_byte, tlast end_of_stream
//  m_axis    | out       | m_axis_tvalid/tready    | tdata out_byte, tlast last_of_run,
//            |           |                         | tuser stream_done
//  cfg       | in        | cfg_valid_i/cfg_ready_o | cfg_data_i direction
//
// Compress: a byte is latched with a table read, then compared; a finished group goes
// out as its flag byte, then its literals. Decompress: an input byte is latched and
// consumed, and each predicted byte it releases takes a lookup and an output step;
// table lookups use the registered memory read. A clearing pass writes 0x20 to every
// table entry after reset, each end of stream and each config write; no input is
// taken meanwhile. A stalled m_axis holds the engine once the output register is full.
`default_nettype none
module predictor_byte_codec
  import pbc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,
  output logic            m_axis_tuser,   // [0] stream_done
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i
);

  pbc_cmd_t  cmd;
  pbc_stat_t stat;
  logic      cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  pbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_acc),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire

### tb/sv/predictor_byte_codec_test.sv
// Testbench for the predictor byte codec: directed and random streams checked by a scoreboard.
`timescale 1ns / 100ps
module predictor_byte_codec_test;
  import pbc_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       end_of_stream;
    int         n_out;
  } byte_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } codec_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;
  logic       m_axis_tuser;           // [0] stream_done
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;

  // predictor state
  logic [7:0] guess_tbl [TableDepth];
  logic [7:0] lit_buf [GroupSize];
  logic [7:0] hist1, hist2, flag_acc;
  int         grp_pos, lit_cnt;
  logic       want_flag;
  logic       dir_mode;

  byte_item_t pending_items [$];
  codec_out_t staged_bytes [$];   // results of items not yet accepted
  codec_out_t out_bytes_due [$];  // results of accepted items, oldest first
  byte_item_t sent_item;
  codec_out_t due_head;

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int send_pct_by_mode [4] = '{0, 66, 0, 32};
  int recv_pct_by_mode [4] = '{0, 0, 66, 32};

  predictor_byte_codec DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [TableAw-1:0] guess_slot();
    return TableAw'(hist1) ^ (TableAw'(hist2) << HashShift);
  endfunction

  function automatic void restart_codec();
    foreach (guess_tbl[i]) guess_tbl[i] = FillByte;
    foreach (lit_buf[i]) lit_buf[i] = 8'h00;
    hist1 = 8'h00;
    hist2 = 8'h00;
    flag_acc = 8'h00;
    grp_pos = 0;
    lit_cnt = 0;
    want_flag = 1'b1;
  endfunction

  // Advances the codec by one input byte, stages its results, returns their count.
  function automatic int codec_step(input logic [7:0] b, input logic eos);
    logic [7:0]         out_seq [GroupSize+1];
    logic [TableAw-1:0] slot;
    logic [7:0]         g;
    int                 n;
    n = 0;
    if (dir_mode == DirCompress) begin
      slot = guess_slot();
      if (guess_tbl[slot] == b) begin
        flag_acc[grp_pos] = 1'b1;
      end else begin
        lit_buf[lit_cnt] = b;
        lit_cnt++;
        guess_tbl[slot] = b;
      end
      hist2 = hist1;
      hist1 = b;
      grp_pos++;
      if (grp_pos >= GroupSize || eos) begin
        out_seq[n] = flag_acc;
        n++;
        for (int k = 0; k < lit_cnt; k++) begin
          out_seq[n] = lit_buf[k];
          n++;
        end
        flag_acc = 8'h00;
        grp_pos = 0;
        lit_cnt = 0;
      end
    end else begin
      if (want_flag) begin
        flag_acc = b;
        grp_pos = 0;
        want_flag = 1'b0;
      end else begin
        guess_tbl[guess_slot()] = b;
        out_seq[n] = b;
        n++;
        hist2 = hist1;
        hist1 = b;
        grp_pos++;
      end
      // release predicted bytes until a literal is needed
      while (grp_pos < GroupSize && flag_acc[grp_pos]) begin
        g = guess_tbl[guess_slot()];
        out_seq[n] = g;
        n++;
        hist2 = hist1;
        hist1 = g;
        grp_pos++;
      end
      if (grp_pos >= GroupSize) begin
        grp_pos = 0;
        want_flag = 1'b1;
      end
    end
    for (int k = 0; k < n; k++)
      staged_bytes.push_back('{out_seq[k], k == n - 1, eos && (k == n - 1)});
    if (eos) restart_codec();
    return n;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic eos);
    int n;
    n = codec_step(b, eos);
    pending_items.push_back('{b, eos, n});
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || out_bytes_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_direction(input logic d);
    wait_drained();
    // an end-of-stream byte may leave no result behind it
    repeat (40) @(posedge clk_i);
    cfg_data_i <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    dir_mode = d;
    restart_codec();
    @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int per_mode);
    logic [7:0] b;
    int         r;
    for (int m = 0; m < 4; m++) begin
      while (pending_items.size() != 0) @(negedge clk_i);
      send_idle_pct = send_pct_by_mode[m];
      recv_stall_pct = recv_pct_by_mode[m];
      if (m == 0) hold_requests++;
      for (int k = 0; k < per_mode; k++) begin
        r = $urandom_range(99);
        if (dir_mode == DirCompress) begin
          if (r < 45) b = guess_tbl[guess_slot()];
          else if (r < 60) b = hist1;
          else b = 8'($urandom_range(255));
        end else if (want_flag) begin
          if (r < 20) b = 8'hFF;
          else if (r < 30) b = 8'h00;
          else if (r < 60) b = 8'($urandom_range(255)) | 8'($urandom_range(255));
          else b = 8'($urandom_range(255));
        end else begin
          b = 8'($urandom_range(255));
        end
        queue_byte(b, $urandom_range(44) == 0);
      end
      // pause the sender mid-stream until the block has emptied
      if (m == 1) wait_drained();
    end
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sent_item = pending_items.pop_front();
        repeat (sent_item.n_out) out_bytes_due.push_back(staged_bytes.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_items[0].data_byte;
          s_axis_tlast <= pending_items[0].end_of_stream;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output backpressure, with an occasional long hold-off once input is flowing
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests && s_axis_tready === 1'b1) begin
      hold_served = hold_served + 1;
      hold_left = 300;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (out_bytes_due.size() == 0) begin
        $error("unexpected transaction: out_byte %h", m_axis_tdata);
        fail_count++;
      end else begin
        due_head = out_bytes_due.pop_front();
        if (m_axis_tdata !== due_head.out_byte) begin
          $error("out_byte: expected %h, got %h", due_head.out_byte, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== due_head.last_of_run) begin
          $error("last_of_run: expected %b, got %b", due_head.last_of_run, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== due_head.stream_done) begin
          $error("stream_done: expected %b, got %b", due_head.stream_done, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [7:0] edge_bytes [8];
    edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    dir_mode = DirCompress;
    restart_codec();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // compress: all-predicted group, all-literal group closed by end of stream,
    // then a one-byte stream
    for (int k = 0; k < GroupSize; k++) queue_byte(FillByte, 1'b0);
    for (int k = 0; k < GroupSize; k++) queue_byte(edge_bytes[k], k == GroupSize - 1);
    queue_byte(8'h41, 1'b1);

    // decompress: full flag, literal closing a group, literal on end of stream,
    // and an end of stream that yields nothing
    write_direction(DirDecompress);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hC3, 1'b1);
    queue_byte(8'h00, 1'b1);

    write_direction(DirCompress);
    run_random_phase(43);
    write_direction(DirDecompress);
    run_random_phase(43);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // each end of stream and direction write costs a full table clear
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
